// File: hw/rtl/upe_pkg.sv
// Shared types and constants for the URI percent encoder.
package upe_pkg;

	localparam int CNT_W = 14;
	localparam int UNITS = 4;
	localparam logic [7:0] CH_PCT = 8'h25;

	// One job: up to four source bytes, each sent as-is or as %HH.
	// A job with no units is the empty end-of-string marker.
	typedef struct packed {
		logic [2:0]            n_units;
		logic [UNITS-1:0][7:0] ubytes;
		logic [UNITS-1:0]      uenc;
		logic                  last;
	} job_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		hex_digit = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
	endfunction

endpackage

// File: hw/rtl/upe_front.sv
// Front end: accepts input bytes, tracks look-ahead state and builds jobs.
module upe_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               in_byte,
	input  logic                     string_last,
	input  logic                     allow_reserved,
	input  logic [upe_pkg::CNT_W-1:0] prefix_limit,
	input  logic                     q_full,
	output logic                     push,
	output upe_pkg::job_t            push_job
);

	typedef enum logic {
		KIND_PCT = 1'b0,
		KIND_UTF = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		CLS_DROP = 2'd0,
		CLS_RAW  = 2'd1,
		CLS_ENC  = 2'd2
	} cls_t;

	typedef struct packed {
		logic [2:0]                    nu;
		logic [upe_pkg::UNITS-1:0][7:0] ub;
		logic [upe_pkg::UNITS-1:0]      ue;
		logic [upe_pkg::CNT_W-1:0]      cnt;
		logic                          lim;
	} acc_t;

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic cls_t classify(input logic [7:0] c, input logic allow);
		logic unres;
		logic res;
		unres = c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
			8'h2D, 8'h2E, 8'h5F, 8'h7E};
		// : / ? # [ ] @ ! $ & ' ( ) * + , ; = |
		res = c inside {8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40, 8'h21,
			8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B,
			8'h3D, 8'h7C};
		if (c >= 8'hF8) begin
			classify = CLS_DROP;
		end else if (unres || (allow && res)) begin
			classify = CLS_RAW;
		end else begin
			classify = CLS_ENC;
		end
	endfunction

	// ucschar (upper range corrected to E1000) and iprivate
	function automatic logic in_range(input logic [20:0] cp);
		logic [4:0] plane;
		plane = cp[20:16];
		in_range = (cp inside {[21'h0000A0:21'h00D7FF], [21'h00F900:21'h00FDCF],
			[21'h00FDF0:21'h00FFEF], [21'h0E1000:21'h0EFFFD],
			[21'h00E000:21'h00F8FF], [21'h0F0000:21'h0FFFFD],
			[21'h100000:21'h10FFFD]}) ||
			(plane >= 5'd1 && plane <= 5'd13 && cp[15:0] <= 16'hFFFD);
	endfunction

	function automatic acc_t add_unit(input acc_t a, input logic [7:0] b, input logic enc);
		acc_t r;
		r = a;
		if (r.nu < 3'(upe_pkg::UNITS)) begin
			r.ub[r.nu[1:0]] = b;
			r.ue[r.nu[1:0]] = enc;
			r.nu = r.nu + 3'd1;
		end
		return r;
	endfunction

	function automatic acc_t count_char(input acc_t a, input logic [upe_pkg::CNT_W-1:0] limit);
		acc_t r;
		r = a;
		r.cnt = r.cnt + 1'b1;
		if (limit != '0 && r.cnt == limit) begin
			r.lim = 1'b1;
		end
		return r;
	endfunction

	function automatic acc_t plain(input acc_t a, input logic [7:0] b, input logic allow,
			input logic [upe_pkg::CNT_W-1:0] limit);
		acc_t r;
		cls_t cls;
		r = a;
		cls = classify(b, allow);
		if (!r.lim) begin
			if (cls == CLS_RAW) begin
				r = add_unit(r, b, 1'b0);
			end else if (cls == CLS_ENC) begin
				r = add_unit(r, b, 1'b1);
			end
			r = count_char(r, limit);
		end
		return r;
	endfunction

	logic [2:0][7:0]            held_q;
	logic [1:0]                 hcount_q;
	kind_t                      kind_q;
	logic [2:0]                 slen_q;
	logic [upe_pkg::CNT_W-1:0]   cnt_q;
	logic                       lim_q;

	acc_t            a;
	logic [2:0][7:0] hb_n;
	logic [1:0]      hc_n;
	kind_t           kind_n;
	logic [2:0]      slen_n;
	logic            fresh;
	logic            two;
	logic [2:0]      need;
	logic [3:0][7:0] seq;
	logic [20:0]     cp;
	logic            accept;

	always_comb begin
		a = '0;
		a.cnt = cnt_q;
		a.lim = lim_q;
		hb_n = held_q;
		hc_n = hcount_q;
		kind_n = kind_q;
		slen_n = slen_q;
		fresh = 1'b0;
		two = 1'b0;
		need = 3'd0;
		seq = '0;
		cp = '0;
		if (!a.lim) begin
			if (hc_n != 2'd0) begin
				if (kind_n == KIND_PCT) begin
					if (is_hex(in_byte)) begin
						if (hc_n == 2'd1) begin
							hb_n[1] = in_byte;
							hc_n = 2'd2;
						end else begin
							a = add_unit(a, upe_pkg::CH_PCT, 1'b0);
							a = add_unit(a, hb_n[1], 1'b0);
							a = add_unit(a, in_byte, 1'b0);
							hc_n = 2'd0;
							a = count_char(a, prefix_limit);
						end
					end else begin
						// broken triplet: flush '%' and any digit, then look at the byte
						two = (hc_n >= 2'd2);
						hc_n = 2'd0;
						a = plain(a, upe_pkg::CH_PCT, allow_reserved, prefix_limit);
						if (two) begin
							a = plain(a, hb_n[1], allow_reserved, prefix_limit);
						end
						fresh = !a.lim;
					end
				end else begin
					need = (slen_n > 3'd4) ? 3'd4 : slen_n;
					if (({1'b0, hc_n} + 3'd1 < need) && hc_n < 2'd3) begin
						hb_n[hc_n] = in_byte;
						hc_n = hc_n + 2'd1;
					end else begin
						seq[2:0] = hb_n;
						seq[hc_n] = in_byte;
						case (hc_n)
							2'd1: cp = {10'd0, seq[0][4:0], seq[1][5:0]};
							2'd2: cp = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
							2'd3: cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
							default: cp = '0;
						endcase
						if (in_range(cp)) begin
							for (int i = 0; i < upe_pkg::UNITS; i++) begin
								if (i <= int'(hc_n)) begin
									a = add_unit(a, seq[i], 1'b1);
								end
							end
						end
						hc_n = 2'd0;
						a = count_char(a, prefix_limit);
					end
				end
			end else begin
				fresh = 1'b1;
			end
			if (fresh) begin
				if (in_byte == upe_pkg::CH_PCT) begin
					hb_n[0] = in_byte;
					kind_n = KIND_PCT;
					hc_n = 2'd1;
				end else if (in_byte < 8'hC0 || in_byte >= 8'hF8) begin
					a = plain(a, in_byte, allow_reserved, prefix_limit);
				end else begin
					hb_n[0] = in_byte;
					kind_n = KIND_UTF;
					slen_n = (in_byte < 8'hE0) ? 3'd2 : ((in_byte < 8'hF0) ? 3'd3 : 3'd4);
					hc_n = 2'd1;
				end
			end
		end
		if (string_last) begin
			// flush a held '%' and digit; an open UTF-8 sequence is dropped
			if (hc_n != 2'd0 && kind_n == KIND_PCT) begin
				two = (hc_n >= 2'd2);
				a = plain(a, upe_pkg::CH_PCT, allow_reserved, prefix_limit);
				if (two) begin
					a = plain(a, hb_n[1], allow_reserved, prefix_limit);
				end
			end
			hc_n = 2'd0;
			kind_n = KIND_PCT;
			slen_n = 3'd0;
			a.cnt = '0;
			a.lim = 1'b0;
		end
	end

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign push = accept && (a.nu != 3'd0 || string_last);

	always_comb begin
		push_job.n_units = a.nu;
		push_job.ubytes = a.ub;
		push_job.uenc = a.ue;
		push_job.last = string_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcount_q <= 2'd0;
			kind_q <= KIND_PCT;
			slen_q <= 3'd0;
			cnt_q <= '0;
			lim_q <= 1'b0;
		end else if (accept) begin
			hcount_q <= hc_n;
			kind_q <= kind_n;
			slen_q <= slen_n;
			cnt_q <= a.cnt;
			lim_q <= a.lim;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= hb_n;
		end
	end

endmodule

// File: hw/rtl/upe_queue.sv
// Short job queue between the front end and the serializer.
module upe_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  upe_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output upe_pkg::job_t head,
	output logic          empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	upe_pkg::job_t   mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

// File: hw/rtl/upe_back.sv
// Back end: expands jobs into output words, one byte per cycle unless the receiver stalls.
module upe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  upe_pkg::job_t head,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          byte_valid,
	output logic          run_last,
	output logic          string_end
);

	logic [1:0] unit_q;
	logic [1:0] phase_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q;
	logic       run_last_q;
	logic       string_end_q;

	logic       load;
	logic       marker;
	logic [7:0] ub;
	logic       enc;
	logic [7:0] nxt_byte;
	logic       unit_done;
	logic       job_done;

	assign load = !empty && (!out_valid_q || out_ready);
	assign marker = (head.n_units == 3'd0);
	assign ub = head.ubytes[unit_q];
	assign enc = head.uenc[unit_q];
	assign unit_done = !enc || (phase_q == 2'd2);
	assign job_done = marker || (unit_done && ({1'b0, unit_q} + 3'd1 == head.n_units));
	assign pop = load && job_done;

	always_comb begin
		if (marker) begin
			nxt_byte = 8'h00;
		end else if (!enc) begin
			nxt_byte = ub;
		end else begin
			case (phase_q)
				2'd0: nxt_byte = upe_pkg::CH_PCT;
				2'd1: nxt_byte = upe_pkg::hex_digit(ub[7:4]);
				default: nxt_byte = upe_pkg::hex_digit(ub[3:0]);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= 2'd0;
			phase_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (job_done) begin
					unit_q <= 2'd0;
					phase_q <= 2'd0;
				end else if (unit_done) begin
					unit_q <= unit_q + 2'd1;
					phase_q <= 2'd0;
				end else begin
					phase_q <= phase_q + 2'd1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= nxt_byte;
			byte_valid_q <= !marker;
			run_last_q <= job_done;
			string_end_q <= job_done && head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign run_last = run_last_q;
	assign string_end = string_end_q;

endmodule

// File: hw/rtl/uri_percent_encoder.sv
// Top level of the URI percent encoder: config registers, front end, queue, back end.
//
// Usage: bytes of a string enter on the in channel (in_valid/in_ready, in_byte,
// string_last on the final byte). Encoded bytes leave on the out channel, one word
// per cycle: out_byte, byte_valid (0 only on the empty end marker), run_last on the
// last word caused by an input byte and string_end on the final word of a string.
// An input that produces nothing and is not the last of its string yields no word.
// Path: an accepted input is written into the queue, and the back end then loads
// its first word into the output register.
// Throughput: the front end takes one byte per cycle while the queue has room;
// the back end sends one byte per cycle while the receiver is ready; a pass-through
// byte yields one word, a %HH byte three, and a kept 4-byte UTF-8 character twelve.
// The output port, one byte per cycle, sets the sustained rate.
// Reset clears the look-ahead state, counters, queue and output register and
// sets both config registers to zero. When the receiver stalls the output word
// holds, the queue fills and then in_ready drops; nothing is lost.
// Config: APB at byte address 0 (allow_reserved) and 4 (prefix_limit); write only
// while idle.
module uri_percent_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        string_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        run_last,
	output logic        string_end
);

	typedef enum logic {
		REG_ALLOW  = 1'b0,
		REG_PREFIX = 1'b1
	} reg_idx_t;

	logic                      allow_reserved_q;
	logic [upe_pkg::CNT_W-1:0] prefix_limit_q;
	logic                      cfg_wr;
	reg_idx_t                  cfg_idx;

	logic          q_full;
	logic          q_push;
	upe_pkg::job_t q_push_job;
	logic          q_pop;
	upe_pkg::job_t q_head;
	logic          q_empty;

	// APB: zero wait states, one register per word address
	assign pready = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_reserved_q <= 1'b0;
			prefix_limit_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ALLOW: allow_reserved_q <= pwdata[0];
				REG_PREFIX: prefix_limit_q <= pwdata[upe_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ALLOW: prdata = {31'd0, allow_reserved_q};
			REG_PREFIX: prdata = {(32 - upe_pkg::CNT_W)'(0), prefix_limit_q};
			default: prdata = '0;
		endcase
	end

	// Front end: classify each byte and turn it into a job of output units
	upe_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.string_last    (string_last),
		.allow_reserved (allow_reserved_q),
		.prefix_limit   (prefix_limit_q),
		.q_full         (q_full),
		.push           (q_push),
		.push_job       (q_push_job)
	);

	// Queue: decouple the byte-rate front from the word-rate back
	upe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_push_job),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// Back end: serialize each job into output words
	upe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.empty      (q_empty),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule

// File: bench/uri_percent_encoder_tb.sv
// Self-checking testbench for the URI percent encoder: random strings, APB setup, word checker.
module uri_percent_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Register indexes; byte address is four times the index.
	localparam int REG_ALLOW_RES  = 0;
	localparam int REG_PREFIX_LIM = 1;

	localparam int MAX_WORDS    = 12;   // most words one input byte can cause
	localparam int DRAIN_CYCLES = 12;   // quiet cycles before a register write and at the end
	localparam int HOLD_CYCLES  = 400;  // long receiver hold-off that backs up the input

	localparam logic [8*16-1:0] HEX_UPPER = "0123456789ABCDEF";
	localparam logic [8*22-1:0] HEX_ANY   = "0123456789abcdefABCDEF";
	localparam logic [8*19-1:0] RESV_SET  = ":/?#[]@!$&'()*+,;=|";
	localparam logic [8*4-1:0]  UNRES_SYM = "-._~";

	// Code points on the edges of the kept ranges.
	localparam logic [20:0] CP_EDGES [26] = '{
		21'h00009F, 21'h0000A0, 21'h00D7FF, 21'h00D800, 21'h00DFFF, 21'h00E000,
		21'h00F8FF, 21'h00F900, 21'h00FDCF, 21'h00FDD0, 21'h00FDEF, 21'h00FDF0,
		21'h00FFEF, 21'h00FFF0, 21'h00FFFD, 21'h01FFFD, 21'h01FFFE, 21'h0E0FFF,
		21'h0E1000, 21'h0EFFFD, 21'h0EFFFE, 21'h0F0000, 21'h0FFFFD, 21'h100000,
		21'h10FFFD, 21'h10FFFF
	};

	// Directed strings, {string_last, byte}.
	localparam logic [8:0] DIRECTED [25] = '{
		{1'b1, 8'h00},                                  // zero byte alone
		{1'b1, 8'hFF},                                  // dropped lead, empty end marker
		{1'b0, "%"}, {1'b0, "4"}, {1'b1, "1"},          // good triplet
		{1'b0, "%"}, {1'b1, "G"},                       // percent then non-hex
		{1'b0, "%"}, {1'b1, "a"},                       // percent and digit flushed at end
		{1'b1, "%"},                                    // lone percent at end
		{1'b0, 8'hC3}, {1'b1, 8'hA9},                   // kept two-byte character
		{1'b0, 8'hC2}, {1'b1, 8'h80},                   // dropped two-byte character
		{1'b0, 8'hF0}, {1'b0, 8'h9F}, {1'b0, 8'h98}, {1'b1, 8'h80},  // kept four-byte
		{1'b1, 8'hE2},                                  // incomplete sequence at end
		{1'b0, 8'h80}, {1'b1, ":"},                     // stray continuation, reserved
		{1'b0, 8'hF3}, {1'b0, 8'hA0}, {1'b0, 8'h80}, {1'b1, 8'h80}   // just below E1000
	};

	// Per-phase setup: register values, idle and stall odds, number of bytes.
	localparam int N_PHASES = 8;
	localparam int CUT_PHASE = 5;   // this phase leaves its last string open
	localparam int PH_ALLOW [N_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0};
	localparam int PH_LIMIT [N_PHASES] = '{0, 1, 9999, 3, 5, 0, 2, 0};
	localparam int PH_SIDLE [N_PHASES] = '{0, 79, 0, 25, 0, 79, 0, 25};
	localparam int PH_RSTALL[N_PHASES] = '{0, 0, 79, 25, 0, 0, 79, 25};
	localparam int PH_BYTES [N_PHASES] = '{50, 55, 45, 55, 45, 45, 55, 40};

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} src_byte_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       vld;
		logic       run_end;
		logic       str_end;
	} enc_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = '0;
	logic        string_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        run_last;
	logic        string_end;

	uri_percent_encoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.string_last (string_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.run_last    (run_last),
		.string_end  (string_end)
	);

	// Source bytes waiting for the driver, words the encoder still owes us.
	src_byte_t pending_bytes[$];
	enc_word_t expected_words[$];
	logic [7:0] enc_out[$];      // words of the byte being predicted
	logic [7:0] str_bytes[$];    // string under construction

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned err_cnt = 0;
	int unsigned words_seen = 0;
	src_byte_t   drv_next;

	// Long hold-off request: toggle hold_req, the hold process counts it out.
	logic        hold_req = 1'b0;
	logic        hold_ack;
	int unsigned hold_cnt;

	// Encoder state as we expect it to be.
	logic                       cfg_allow_res = 1'b0;
	logic [upe_pkg::CNT_W-1:0]  cfg_prefix_lim = '0;
	logic [7:0]                 held_q [3] = '{default: '0};
	logic [1:0]                 held_cnt = '0;
	logic                       held_utf8 = 1'b0;
	logic [2:0]                 seq_len = '0;
	logic [upe_pkg::CNT_W-1:0]  char_cnt = '0;
	logic                       limit_hit = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------- prediction ----------------

	function automatic bit is_hex_ch(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic bit is_unres(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			c == "-" || c == "." || c == "_" || c == "~";
	endfunction

	function automatic bit is_resv(input logic [7:0] c);
		for (int k = 0; k < 19; k++) begin
			if (RESV_SET[8*k +: 8] == c)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// ucschar (upper block starting at E1000) and iprivate ranges
	function automatic bit cp_kept(input logic [20:0] cp);
		logic [4:0] plane;
		plane = cp[20:16];
		return (cp >= 21'h0000A0 && cp <= 21'h00D7FF) ||
			(cp >= 21'h00F900 && cp <= 21'h00FDCF) ||
			(cp >= 21'h00FDF0 && cp <= 21'h00FFEF) ||
			(plane >= 5'd1 && plane <= 5'd13 && cp[15:0] <= 16'hFFFD) ||
			(cp >= 21'h0E1000 && cp <= 21'h0EFFFD) ||
			(cp >= 21'h00E000 && cp <= 21'h00F8FF) ||
			(cp >= 21'h0F0000 && cp <= 21'h0FFFFD) ||
			(cp >= 21'h100000 && cp <= 21'h10FFFD);
	endfunction

	function automatic logic [7:0] hex_upper(input logic [3:0] nib);
		return HEX_UPPER[8*(15 - nib) +: 8];
	endfunction

	task automatic emit(input logic [7:0] c);
		if (enc_out.size() < MAX_WORDS)
			enc_out.push_back(c);
	endtask

	task automatic emit_pct(input logic [7:0] c);
		emit(upe_pkg::CH_PCT);
		emit(hex_upper(c[7:4]));
		emit(hex_upper(c[3:0]));
	endtask

	task automatic bump_count();
		char_cnt = char_cnt + 1'b1;
		if (cfg_prefix_lim != 0 && char_cnt == cfg_prefix_lim)
			limit_hit = 1'b1;
	endtask

	// One byte that stands as a character by itself.
	task automatic plain_char(input logic [7:0] c);
		if (limit_hit)
			return;
		if (c >= 8'hF8) begin
			// dropped, still counts
		end else if (is_unres(c) || (cfg_allow_res && is_resv(c))) begin
			emit(c);
		end else begin
			emit_pct(c);
		end
		bump_count();
	endtask

	task automatic encode_byte(input logic [7:0] b);
		logic [7:0]  seq_b [4];
		logic [20:0] cp;
		int          n;
		int          k;
		if (limit_hit)
			return;
		if (held_cnt != 0) begin
			if (!held_utf8) begin
				if (is_hex_ch(b)) begin
					if (held_cnt == 1) begin
						held_q[1] = b;
						held_cnt = 2'd2;
					end else begin
						emit(upe_pkg::CH_PCT);
						emit(held_q[1]);
						emit(b);
						held_cnt = '0;
						bump_count();
					end
					return;
				end
				// broken triplet: flush the percent and any digit, then look at b afresh
				n = (held_cnt > 2) ? 2 : int'(held_cnt);
				held_cnt = '0;
				plain_char(upe_pkg::CH_PCT);
				if (n == 2)
					plain_char(held_q[1]);
				if (limit_hit)
					return;
			end else begin
				n = (seq_len > 4) ? 4 : int'(seq_len);
				if (held_cnt + 1 < n && held_cnt < 3) begin
					held_q[held_cnt] = b;
					held_cnt = held_cnt + 1'b1;
					return;
				end
				for (k = 0; k < held_cnt && k < 3; k++)
					seq_b[k] = held_q[k];
				seq_b[k] = b;
				n = k + 1;
				held_cnt = '0;
				case (n)
					2: cp = {16'h0, seq_b[0][4:0]};
					3: cp = {17'h0, seq_b[0][3:0]};
					default: cp = {18'h0, seq_b[0][2:0]};
				endcase
				for (k = 1; k < n; k++)
					cp = {cp[14:0], seq_b[k][5:0]};
				if (cp_kept(cp)) begin
					for (k = 0; k < n; k++)
						emit_pct(seq_b[k]);
				end
				bump_count();
				return;
			end
		end
		if (b == upe_pkg::CH_PCT) begin
			held_q[0] = b;
			held_utf8 = 1'b0;
			held_cnt = 2'd1;
		end else if (b < 8'hC0 || b >= 8'hF8) begin
			plain_char(b);
		end else begin
			held_q[0] = b;
			held_utf8 = 1'b1;
			seq_len = (b < 8'hE0) ? 3'd2 : (b < 8'hF0) ? 3'd3 : 3'd4;
			held_cnt = 2'd1;
		end
	endtask

	// Flush a held percent and digit; drop a partial sequence; clear per-string state.
	task automatic close_string();
		int n;
		if (held_cnt != 0 && !held_utf8) begin
			n = int'(held_cnt);
			held_cnt = '0;
			plain_char(upe_pkg::CH_PCT);
			if (n >= 2)
				plain_char(held_q[1]);
		end
		held_cnt = '0;
		held_utf8 = 1'b0;
		seq_len = '0;
		char_cnt = '0;
		limit_hit = 1'b0;
	endtask

	task automatic predict_words(input logic [7:0] b, input logic last);
		enc_word_t w;
		enc_out.delete();
		encode_byte(b);
		if (last)
			close_string();
		if (enc_out.size() == 0) begin
			// nothing emitted: only the last byte of a string yields the empty marker
			if (last) begin
				w.ch = '0;
				w.vld = 1'b0;
				w.run_end = 1'b1;
				w.str_end = 1'b1;
				expected_words.push_back(w);
			end
		end else begin
			foreach (enc_out[k]) begin
				w.ch = enc_out[k];
				w.vld = 1'b1;
				w.run_end = (k == enc_out.size() - 1);
				w.str_end = w.run_end && last;
				expected_words.push_back(w);
			end
		end
	endtask

	task automatic check_word();
		enc_word_t got;
		enc_word_t want;
		got.ch = out_byte;
		got.vld = byte_valid;
		got.run_end = run_last;
		got.str_end = string_end;
		if (expected_words.size() == 0) begin
			if (err_cnt < 10)
				$display("word %0d: unexpected, got byte %02h vld %b run_last %b end %b",
					words_seen, got.ch, got.vld, got.run_end, got.str_end);
			err_cnt++;
		end else begin
			want = expected_words.pop_front();
			if (got !== want) begin
				if (err_cnt < 10)
					$display("word %0d: want %02h/%b/%b/%b got %02h/%b/%b/%b",
						words_seen, want.ch, want.vld, want.run_end, want.str_end,
						got.ch, got.vld, got.run_end, got.str_end);
				err_cnt++;
			end
		end
		words_seen++;
	endtask

	// ---------------- driver, monitor, hold-off ----------------

	// Drive the input channel. Predict each word the moment the byte is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= '0;
			string_last <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_words(in_byte, string_last);
			// hold the byte until taken; otherwise offer the next one or idle
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_next = pending_bytes.pop_front();
					in_valid <= 1'b1;
					in_byte <= drv_next.ch;
					string_last <= drv_next.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check each accepted word against the oldest expectation; randomize out_ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_word();
			out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Count out a long receiver hold-off each time hold_req toggles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			hold_ack <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (hold_req != hold_ack) begin
			hold_cnt <= HOLD_CYCLES;
			hold_ack <= hold_req;
		end
	end

	// ---------------- stimulus ----------------

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(input int idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ALLOW_RES:  cfg_allow_res = value[0];
			REG_PREFIX_LIM: cfg_prefix_lim = value[upe_pkg::CNT_W-1:0];
			default: ;
		endcase
	endtask

	// Wait until every byte is taken and every word seen, then let the pipeline settle.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [20:0] pick_code_point();
		case ($urandom_range(0, 3))
			0: return CP_EDGES[$urandom_range(0, 25)];
			1: return 21'($urandom_range(21'h80, 21'h7FF));
			2: return 21'($urandom_range(21'h800, 21'hFFFF));
			default: return 21'($urandom_range(21'h10000, 21'h10FFFF));
		endcase
	endfunction

	// Append one character's worth of bytes, mostly well formed.
	task automatic add_token();
		int unsigned pick;
		int unsigned k;
		logic [7:0]  c;
		logic [20:0] cp;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			k = $urandom_range(0, 65);
			if (k < 10)
				c = 8'("0" + k);
			else if (k < 36)
				c = 8'("a" + k - 10);
			else if (k < 62)
				c = 8'("A" + k - 36);
			else
				c = UNRES_SYM[8*(k - 62) +: 8];
			str_bytes.push_back(c);
		end else if (pick < 32) begin
			k = $urandom_range(0, 18);
			str_bytes.push_back(RESV_SET[8*k +: 8]);
		end else if (pick < 40) begin
			str_bytes.push_back(8'($urandom_range(0, 127)));
		end else if (pick < 50) begin
			// well-formed triplet, digits of either case
			str_bytes.push_back(upe_pkg::CH_PCT);
			k = $urandom_range(0, 21);
			str_bytes.push_back(HEX_ANY[8*k +: 8]);
			k = $urandom_range(0, 21);
			str_bytes.push_back(HEX_ANY[8*k +: 8]);
		end else if (pick < 56) begin
			// broken triplet: percent, maybe a digit, then a non-hex byte
			str_bytes.push_back(upe_pkg::CH_PCT);
			if ($urandom_range(0, 1)) begin
				k = $urandom_range(0, 21);
				str_bytes.push_back(HEX_ANY[8*k +: 8]);
			end
			do c = 8'($urandom_range(0, 255)); while (is_hex_ch(c));
			str_bytes.push_back(c);
		end else if (pick < 74) begin
			cp = pick_code_point();
			if (cp < 21'h800) begin
				str_bytes.push_back({3'b110, cp[10:6]});
			end else if (cp < 21'h10000) begin
				str_bytes.push_back({4'b1110, cp[15:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
			end else begin
				str_bytes.push_back({5'b11110, cp[20:18]});
				str_bytes.push_back({2'b10, cp[17:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
			end
			str_bytes.push_back({2'b10, cp[5:0]});
		end else if (pick < 82) begin
			str_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 88) begin
			str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
		end else if (pick < 92) begin
			str_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
		end else begin
			// any lead byte with arbitrary follow-up bytes, possibly cut short
			str_bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
			repeat ($urandom_range(0, 3))
				str_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		src_byte_t   item;
		int unsigned added;
		// reset once, release away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_ALLOW_RES, 32'd0);
		write_reg(REG_PREFIX_LIM, 32'd0);

		// directed strings, no idling
		@(negedge clk);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (DIRECTED[k]) begin
			item.ch = DIRECTED[k][7:0];
			item.last = DIRECTED[k][8];
			pending_bytes.push_back(item);
		end
		wait_drained();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_reg(REG_ALLOW_RES, 32'(PH_ALLOW[ph]));
			write_reg(REG_PREFIX_LIM, 32'(PH_LIMIT[ph]));
			@(negedge clk);
			send_idle_pct = PH_SIDLE[ph];
			recv_stall_pct = PH_RSTALL[ph];
			added = 0;
			while (added < PH_BYTES[ph]) begin
				str_bytes.delete();
				repeat ($urandom_range(1, 8))
					add_token();
				foreach (str_bytes[k]) begin
					item.ch = str_bytes[k];
					item.last = (k == str_bytes.size() - 1);
					pending_bytes.push_back(item);
				end
				added += str_bytes.size();
			end
			// leave one string open across a register change
			if (ph == CUT_PHASE)
				pending_bytes[pending_bytes.size() - 1].last = 1'b0;
			// first phase: starve the output so the input backs up
			if (ph == 0)
				hold_req = ~hold_req;
			wait_drained();
		end

		if (err_cnt == 0)
			$display("uri_percent_encoder_tb: done, clean");
		else
			$display("uri_percent_encoder_tb: done, errors");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#10_000_000;
		$display("uri_percent_encoder_tb: done, errors");
		$finish;
	end

endmodule
